>>> src/rfpc_pkg.sv
// Package for the rounded frame pixel compositor.
// Shared widths, register indexes, reset values and the side-band record.
// No dependencies.
`default_nettype none

package rfpc_pkg;

  localparam int unsigned COORD_BITS_DEF    = 13;
  localparam int unsigned FRACTION_BITS_DEF = 8;
  localparam int unsigned SIDE_BITS         = 12;
  localparam int unsigned COLOR_BITS        = 24;
  localparam int unsigned CFG_DATA_W        = 48;
  localparam int unsigned CFG_IDX_W         = 3;

  localparam logic [23:0] BG_RESET     = 24'h000000;
  localparam logic [31:0] BORDER_RESET = 32'h000000FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKGROUND = 3'd0,
    CFG_BORDER     = 3'd1,
    CFG_FRAME_SIZE = 3'd2,
    CFG_MARGINS    = 3'd3,
    CFG_BORDER_W   = 3'd4,
    CFG_RADII      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                  in_frame;
    logic [SIDE_BITS-1:0]  rad;
    logic [SIDE_BITS-1:0]  bw;
    logic [COLOR_BITS-1:0] content;
  } sb_t;

endpackage

`default_nettype wire

>>> src/rounded_frame_pixel_compositor.sv
// Rounded frame pixel compositor, top level: config registers and pixel pipeline.
// Depends on rfpc_pkg.
`default_nettype none

// One composed pixel per clock while the output does not stall. The pipelined
// square root, which yields one root bit per stage for the corner distance,
// makes up most of the pipeline. Each transfer on the input may follow the previous one
// in the next cycle; a stall on the output holds the whole pipeline, and the input
// stalls only while a finished pixel waits there. Write configuration only while
// no pixel is in flight.
module rounded_frame_pixel_compositor #(
  parameter int unsigned COORD_BITS    = rfpc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rfpc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rfpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rfpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [COORD_BITS-1:0]          pixel_x_i,
  input  wire logic [COORD_BITS-1:0]          pixel_y_i,
  input  wire logic [rfpc_pkg::COLOR_BITS-1:0] content_rgb_i,
  input  wire logic                           content_valid_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [rfpc_pkg::COLOR_BITS-1:0]     pixel_rgb_o
);
  import rfpc_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned SB   = SIDE_BITS;
  localparam int unsigned XW   = ((CB > SB) ? CB : SB) + 2;
  localparam int unsigned DW   = SB + 1;
  localparam int unsigned SQW  = 2 * DW;
  localparam int unsigned RW   = 2 * DW + 2 * F;
  localparam int unsigned QW   = RW / 2;
  localparam int unsigned CMPW = QW + 2;
  localparam int unsigned TW   = F + 1;
  localparam int unsigned BLW  = 8 + F + 1;

  localparam logic signed [XW-1:0]   ONE_X  = XW'(1);
  localparam logic signed [CMPW-1:0] ONE_C  = CMPW'(1) << F;
  localparam logic signed [CMPW-1:0] HALF_C = CMPW'(1) << (F - 1);
  localparam logic [TW-1:0]          ONE_T  = TW'(1) << F;

  // configuration registers
  logic [23:0]     bg_q;
  logic [31:0]     brd_q;
  logic [2*CB-1:0] fsz_q;
  logic [47:0]     mar_q, bwd_q, rad_q;
  logic [23:0]     bc_d, bc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q  <= BG_RESET;
      brd_q <= BORDER_RESET;
      fsz_q <= '0;
      mar_q <= '0;
      bwd_q <= '0;
      rad_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BACKGROUND: bg_q  <= cfg_data_i[23:0];
        CFG_BORDER:     brd_q <= cfg_data_i[31:0];
        CFG_FRAME_SIZE: fsz_q <= cfg_data_i[2*CB-1:0];
        CFG_MARGINS:    mar_q <= cfg_data_i[47:0];
        CFG_BORDER_W:   bwd_q <= cfg_data_i[47:0];
        CFG_RADII:      rad_q <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // border premixed over background: floor(v/255) as (v + 1 + (v >> 8)) >> 8
  always_comb begin
    logic [16:0] v;
    logic [16:0] q;
    bc_d = '0;
    for (int c = 0; c < 3; c++) begin
      v = 17'(bg_q[8*c +: 8]) * 17'(8'd255 - brd_q[7:0])
        + 17'(brd_q[8+8*c +: 8]) * 17'(brd_q[7:0]);
      q = (v + 17'd1 + (v >> 8)) >> 8;
      bc_d[8*c +: 8] = q[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    bc_q <= bc_d;
  end

  // config-derived geometry
  logic signed [XW-1:0] mt_s, ml_s, mb_s, mr_s, fw_s, fh_s, cw_s, ch_s;
  logic signed [XW-1:0] b0_s, b1_s, b2_s, b3_s, r0_s, r1_s, r2_s, r3_s;
  logic [SB-1:0]        b0, b1, b2, b3, r0, r1, r2, r3;

  assign b0 = bwd_q[0*SB +: SB];
  assign b1 = bwd_q[1*SB +: SB];
  assign b2 = bwd_q[2*SB +: SB];
  assign b3 = bwd_q[3*SB +: SB];
  assign r0 = rad_q[0*SB +: SB];
  assign r1 = rad_q[1*SB +: SB];
  assign r2 = rad_q[2*SB +: SB];
  assign r3 = rad_q[3*SB +: SB];
  assign mt_s = $signed({{(XW-SB){1'b0}}, mar_q[0*SB +: SB]});
  assign ml_s = $signed({{(XW-SB){1'b0}}, mar_q[1*SB +: SB]});
  assign mb_s = $signed({{(XW-SB){1'b0}}, mar_q[2*SB +: SB]});
  assign mr_s = $signed({{(XW-SB){1'b0}}, mar_q[3*SB +: SB]});
  assign b0_s = $signed({{(XW-SB){1'b0}}, b0});
  assign b1_s = $signed({{(XW-SB){1'b0}}, b1});
  assign b2_s = $signed({{(XW-SB){1'b0}}, b2});
  assign b3_s = $signed({{(XW-SB){1'b0}}, b3});
  assign r0_s = $signed({{(XW-SB){1'b0}}, r0});
  assign r1_s = $signed({{(XW-SB){1'b0}}, r1});
  assign r2_s = $signed({{(XW-SB){1'b0}}, r2});
  assign r3_s = $signed({{(XW-SB){1'b0}}, r3});
  assign fw_s = $signed({{(XW-CB){1'b0}}, fsz_q[CB-1:0]});
  assign fh_s = $signed({{(XW-CB){1'b0}}, fsz_q[2*CB-1:CB]});
  assign cw_s = fw_s - ml_s - mr_s;
  assign ch_s = fh_s - mt_s - mb_s;

  logic adv;
  logic out_v_q;
  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  // input register
  logic          s0_v_q;
  logic [CB-1:0] s0_x_q, s0_y_q;
  logic [23:0]   s0_c_q;
  logic          s0_cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_x_q  <= pixel_x_i;
      s0_y_q  <= pixel_y_i;
      s0_c_q  <= content_rgb_i;
      s0_cv_q <= content_valid_i;
    end
  end

  // stage A: region tests and corner choice
  logic signed [XW-1:0] sa_rx_d, sa_ry_d, sa_rx_q, sa_ry_q;
  sb_t                  sa_sb_d, sa_sb_q;
  logic                 sa_v_q;

  always_comb begin
    logic border;
    sa_rx_d = $signed({{(XW-CB){1'b0}}, s0_x_q}) - ml_s;
    sa_ry_d = $signed({{(XW-CB){1'b0}}, s0_y_q}) - mt_s;
    sa_sb_d.in_frame = (sa_rx_d >= 0) && (sa_rx_d < cw_s) &&
                       (sa_ry_d >= 0) && (sa_ry_d < ch_s);
    border = (sa_ry_d < b0_s) || (sa_ry_d >= ch_s - b2_s) ||
             (sa_rx_d < b1_s) || (sa_rx_d >= cw_s - b3_s);
    sa_sb_d.content = (border || !s0_cv_q) ? bc_q : s0_c_q;
    priority if (sa_rx_d < r0_s && sa_ry_d < r0_s) begin
      sa_sb_d.rad = r0;
      sa_sb_d.bw  = (b0 > b1) ? b0 : b1;
    end else if (sa_rx_d >= cw_s - r1_s && sa_ry_d < r1_s) begin
      sa_sb_d.rad = r1;
      sa_sb_d.bw  = (b0 > b3) ? b0 : b3;
    end else if (sa_rx_d >= cw_s - r2_s && sa_ry_d >= ch_s - r2_s) begin
      sa_sb_d.rad = r2;
      sa_sb_d.bw  = (b2 > b3) ? b2 : b3;
    end else if (sa_rx_d < r3_s && sa_ry_d >= ch_s - r3_s) begin
      sa_sb_d.rad = r3;
      sa_sb_d.bw  = (b2 > b1) ? b2 : b1;
    end else begin
      sa_sb_d.rad = '0;
      sa_sb_d.bw  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
    end else if (adv) begin
      sa_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_rx_q <= sa_rx_d;
      sa_ry_q <= sa_ry_d;
      sa_sb_q <= sa_sb_d;
    end
  end

  // stage B: half-pixel offsets from the arc center
  logic [DW-1:0] sb_dx_d, sb_dy_d, sb_dx_q, sb_dy_q;
  sb_t           sb_sb_q;
  logic          sb_v_q;

  always_comb begin
    logic signed [XW-1:0] rad_s, lx, rxo, ty, by, dxs, dys;
    logic                 in_l, in_r, in_t, in_b;
    rad_s = $signed({{(XW-SB){1'b0}}, sa_sb_q.rad});
    lx    = ((rad_s - sa_rx_q) <<< 1) - ONE_X;
    rxo   = ((sa_rx_q - cw_s + rad_s) <<< 1) + ONE_X;
    ty    = ((rad_s - sa_ry_q) <<< 1) - ONE_X;
    by    = ((sa_ry_q - ch_s + rad_s) <<< 1) + ONE_X;
    in_l  = sa_rx_q < rad_s;
    in_r  = sa_rx_q >= cw_s - rad_s;
    in_t  = sa_ry_q < rad_s;
    in_b  = sa_ry_q >= ch_s - rad_s;
    priority if (in_l && in_t) begin
      dxs = lx;
      dys = ty;
    end else if (in_r && in_t) begin
      dxs = rxo;
      dys = ty;
    end else if (in_r && in_b) begin
      dxs = rxo;
      dys = by;
    end else if (in_l && in_b) begin
      dxs = lx;
      dys = by;
    end else begin
      dxs = '0;
      dys = '0;
    end
    sb_dx_d = (dxs < 0) ? '0 : dxs[DW-1:0];
    sb_dy_d = (dys < 0) ? '0 : dys[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= 1'b0;
    end else if (adv) begin
      sb_v_q <= sa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_dx_q <= sb_dx_d;
      sb_dy_q <= sb_dy_d;
      sb_sb_q <= sa_sb_q;
    end
  end

  // stage C: squares
  logic [SQW-1:0] sc_sqx_q, sc_sqy_q;
  sb_t            sc_sb_q;
  logic           sc_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else if (adv) begin
      sc_v_q <= sb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_sqx_q <= SQW'(sb_dx_q) * SQW'(sb_dx_q);
      sc_sqy_q <= SQW'(sb_dy_q) * SQW'(sb_dy_q);
      sc_sb_q  <= sb_sb_q;
    end
  end

  // square root, one result bit per stage
  logic [RW-1:0] rem_q  [QW+1];
  logic [QW-1:0] root_q [QW+1];
  sb_t           sq_sb_q[QW+1];
  logic          sq_v_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      sq_v_q[0] <= sc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]   <= (RW'(sc_sqx_q) + RW'(sc_sqy_q)) << (2 * F - 2);
      root_q[0]  <= '0;
      sq_sb_q[0] <= sc_sb_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    localparam int unsigned I = QW - 1 - k;
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = (RW'(root_q[k]) << (I + 1)) + (RW'(1) << (2 * I));
    assign ge    = rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k+1]   <= ge ? (rem_q[k] - trial) : rem_q[k];
        root_q[k+1]  <= root_q[k] | (QW'(ge) << I);
        sq_sb_q[k+1] <= sq_sb_q[k];
      end
    end
  end

  // stage E: arc band selection
  logic [23:0]   se_a_d, se_b_d, se_a_q, se_b_q;
  logic [TW-1:0] se_t_d, se_t_q;
  logic          se_v_q;

  always_comb begin
    logic signed [CMPW-1:0] dist_fx, rad_f, rad_m1, inn_f, inn_m1, tf;
    logic [SB-1:0]          inner;
    sb_t                    s;
    s       = sq_sb_q[QW];
    inner   = (s.rad > s.bw) ? (s.rad - s.bw) : '0;
    dist_fx = $signed({2'b00, root_q[QW]}) - HALF_C;
    rad_f   = $signed({{(CMPW-SB-F){1'b0}}, s.rad, {F{1'b0}}});
    inn_f   = $signed({{(CMPW-SB-F){1'b0}}, inner, {F{1'b0}}});
    rad_m1  = rad_f - ONE_C;
    inn_m1  = inn_f - ONE_C;
    se_a_d  = s.content;
    se_b_d  = bc_q;
    tf      = '0;
    priority if (!s.in_frame) begin
      se_a_d = bg_q;
    end else if (s.rad == '0) begin
      se_a_d = s.content;
    end else if (dist_fx > rad_f) begin
      se_a_d = bg_q;
    end else if (dist_fx > rad_m1) begin
      se_a_d = bc_q;
      se_b_d = bg_q;
      tf     = dist_fx - rad_m1;
    end else if (dist_fx > inn_f) begin
      se_a_d = bc_q;
    end else if (dist_fx > inn_m1) begin
      se_a_d = s.content;
      se_b_d = bc_q;
      tf     = dist_fx - inn_m1;
    end else begin
      se_a_d = s.content;
    end
    se_t_d = tf[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_v_q <= 1'b0;
    end else if (adv) begin
      se_v_q <= sq_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      se_a_q <= se_a_d;
      se_b_q <= se_b_d;
      se_t_q <= se_t_d;
    end
  end

  // stage F: blend products
  logic [BLW-1:0] sf_sum_d [3];
  logic [BLW-1:0] sf_sum_q [3];
  logic           sf_v_q;

  always_comb begin
    logic [TW-1:0] omt;
    omt = ONE_T - se_t_q;
    for (int c = 0; c < 3; c++) begin
      sf_sum_d[c] = BLW'(se_a_q[8*c +: 8]) * BLW'(omt) + BLW'(se_b_q[8*c +: 8]) * BLW'(se_t_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_v_q <= 1'b0;
    end else if (adv) begin
      sf_v_q <= se_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sf_sum_q <= sf_sum_d;
    end
  end

  // output register
  logic [23:0] out_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= sf_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rgb_q <= {sf_sum_q[2][F +: 8], sf_sum_q[1][F +: 8], sf_sum_q[0][F +: 8]};
    end
  end

  assign out_valid_o = out_v_q;
  assign pixel_rgb_o = out_rgb_q;

endmodule

`default_nettype wire

>>> src/rfpc_chk.sv
// Port-level checker for the rounded frame pixel compositor, with its bind.
// Depends on rounded_frame_pixel_compositor.
`default_nettype none

module rfpc_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [23:0] pixel_rgb_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transfer dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_rgb_o))
    else $error("stalled pixel changed");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting output");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty in reset");

endmodule

bind rounded_frame_pixel_compositor rfpc_chk u_rfpc_chk (.*);

`default_nettype wire
